/* src/integer_to_radix_digits_defines.svh */
// Assertion macros shared by the integer_to_radix_digits RTL.
// Expects signals clk and arst_n in the scope where a macro is used.
`ifndef INTEGER_TO_RADIX_DIGITS_DEFINES_SVH
`define INTEGER_TO_RADIX_DIGITS_DEFINES_SVH

// same-cycle implication
`define ITD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ITD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/itd_pkg.sv */
// Shared types, constants and helpers for integer_to_radix_digits.
// No dependencies.
`default_nettype none

package itd_pkg;

	localparam int unsigned IN_W    = 40;
	localparam int unsigned OUT_W   = 8;
	localparam int unsigned NUM_W   = 32;
	localparam int unsigned RADIX_W = 5;
	localparam int unsigned CHAR_W  = 7;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
	localparam logic [CHAR_W-1:0] CHAR_ERR   = 7'h00;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'h37;

	// command word passed from front to back alongside the magnitude
	typedef struct packed {
		logic               bad;
		logic               neg;
		logic [RADIX_W-1:0] radix;
	} cmd_t;

	// digit value to ASCII: 0-9 then A-F
	function automatic logic [CHAR_W-1:0] glyph(input logic [3:0] d);
		if (d < 4'd10)
			return CHAR_ZERO + {3'b000, d};
		else
			return CHAR_ALPHA + {3'b000, d};
	endfunction

endpackage

`default_nettype wire

/* src/itd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module itd_ram #(
	parameter int unsigned WIDTH = 4,
	parameter int unsigned DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* src/itd_fifo.sv */
// Small register FIFO decoupling the front classifier from the back converter.
// No dependencies.
`default_nettype none

module itd_fifo #(
	parameter int unsigned WIDTH = 39,
	parameter int unsigned DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	output logic                  full,
	input  wire logic             pop,
	output logic                  valid,
	output logic      [WIDTH-1:0] dout
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign valid   = (cnt_q != '0);
	assign dout    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

/* src/itd_front.sv */
// Front end: accepts input transfers, checks the radix, splits sign and magnitude.
// Depends on itd_pkg.
`default_nettype none

module itd_front #(
	parameter int unsigned VALUE_BITS = 32
) (
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [itd_pkg::NUM_W-1:0]      number,
	input  wire logic [itd_pkg::RADIX_W-1:0]    radix,
	input  wire logic                           q_full,
	output logic                                q_push,
	output itd_pkg::cmd_t                       q_cmd,
	output logic      [VALUE_BITS-1:0]          q_mag
);

	logic [VALUE_BITS-1:0] value;

	generate
		if (VALUE_BITS <= itd_pkg::NUM_W) begin : g_trunc
			assign value = number[VALUE_BITS-1:0];
		end else begin : g_sext
			assign value = {{(VALUE_BITS - itd_pkg::NUM_W){number[itd_pkg::NUM_W-1]}}, number};
		end
	endgenerate

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		q_cmd.radix = radix;
		q_cmd.neg   = value[VALUE_BITS-1];
		q_cmd.bad   = (radix < itd_pkg::RADIX_MIN) || (radix > itd_pkg::RADIX_MAX);
		q_mag       = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
	end

endmodule

`default_nettype wire

/* src/itd_back.sv */
// Back end: long division one byte per cycle, digit store, character output.
// Depends on itd_pkg and itd_ram.
`default_nettype none

module itd_back #(
	parameter int unsigned VALUE_BITS = 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      q_valid,
	input  wire itd_pkg::cmd_t             q_cmd,
	input  wire logic [VALUE_BITS-1:0]     q_mag,
	output logic                           q_pop,
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	output logic      [itd_pkg::OUT_W-1:0] m_tdata,
	output logic                           m_tlast,
	output logic                           m_tuser
);

	localparam int unsigned CHUNKS = (VALUE_BITS + 7) / 8;
	localparam int unsigned PW     = CHUNKS * 8;
	localparam int unsigned CCW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int unsigned AW     = $clog2(VALUE_BITS);
	localparam int unsigned CNTW   = $clog2(VALUE_BITS + 1);

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_ERR,
		B_EMIT
	} state_t;

	state_t                         state_q;
	logic [PW-1:0]                  magnitude_q;
	logic [3:0]                     rem_q;
	logic [itd_pkg::RADIX_W-1:0]    radix_q;
	logic                           sign_pend_q;
	logic [CCW-1:0]                 chunk_q;
	logic [CNTW-1:0]                digit_count_q;
	logic [AW-1:0]                  ptr_q;
	logic                           data_ok_q;
	logic                           out_valid_q;
	logic [itd_pkg::CHAR_W-1:0]     out_char_q;
	logic                           out_last_q;
	logic                           out_bad_q;

	logic [7:0]                     qbits;
	logic [3:0]                     rem_nx;
	logic [PW-1:0]                  mag_nx;
	logic                           last_chunk;
	logic                           div_done;
	logic                           out_free;
	logic                           put_err;
	logic                           put_sign;
	logic                           put_digit;
	logic                           ram_we;
	logic [AW-1:0]                  ram_raddr;
	logic [3:0]                     ram_rdata;

	// eight restoring-division steps on the top byte
	always_comb begin
		logic [3:0]                  r;
		logic [itd_pkg::RADIX_W-1:0] t;
		r     = rem_q;
		qbits = '0;
		for (int i = 0; i < 8; i++) begin
			t = {r, magnitude_q[PW-1-i]};
			if (t >= radix_q) begin
				qbits[7-i] = 1'b1;
				r          = 4'(t - radix_q);
			end else begin
				r = t[3:0];
			end
		end
		rem_nx = r;
		mag_nx = (magnitude_q << 8) | PW'(qbits);
	end

	assign last_chunk = (chunk_q == CCW'(CHUNKS - 1));
	assign div_done   = (mag_nx == '0) || (digit_count_q + 1'b1 == CNTW'(VALUE_BITS));
	assign ram_we     = (state_q == B_DIV) && last_chunk;

	assign out_free  = !out_valid_q || m_tready;
	assign put_err   = (state_q == B_ERR) && out_free;
	assign put_sign  = (state_q == B_EMIT) && out_free && sign_pend_q;
	assign put_digit = (state_q == B_EMIT) && out_free && !sign_pend_q && data_ok_q;
	assign ram_raddr = (put_digit && ptr_q != '0) ? ptr_q - 1'b1 : ptr_q;
	assign q_pop     = (state_q == B_IDLE) && q_valid;

	itd_ram #(
		.WIDTH (4),
		.DEPTH (VALUE_BITS)
	) u_digit_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (digit_count_q[AW-1:0]),
		.wdata (rem_nx),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= B_IDLE;
			magnitude_q   <= '0;
			rem_q         <= '0;
			radix_q       <= '0;
			sign_pend_q   <= 1'b0;
			chunk_q       <= '0;
			digit_count_q <= '0;
			ptr_q         <= '0;
			data_ok_q     <= 1'b0;
			out_valid_q   <= 1'b0;
			out_char_q    <= '0;
			out_last_q    <= 1'b0;
			out_bad_q     <= 1'b0;
		end else begin
			if (m_tready && !(put_err || put_sign || put_digit))
				out_valid_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (q_valid) begin
						if (q_cmd.bad) begin
							state_q <= B_ERR;
						end else begin
							state_q       <= B_DIV;
							magnitude_q   <= PW'(q_mag);
							radix_q       <= q_cmd.radix;
							sign_pend_q   <= q_cmd.neg;
							rem_q         <= '0;
							chunk_q       <= '0;
							digit_count_q <= '0;
						end
					end
				end
				B_DIV: begin
					magnitude_q <= mag_nx;
					if (last_chunk) begin
						rem_q         <= '0;
						chunk_q       <= '0;
						digit_count_q <= digit_count_q + 1'b1;
						if (div_done) begin
							state_q   <= B_EMIT;
							ptr_q     <= digit_count_q[AW-1:0];
							data_ok_q <= 1'b0;
						end
					end else begin
						rem_q   <= rem_nx;
						chunk_q <= chunk_q + 1'b1;
					end
				end
				B_ERR: begin
					if (put_err) begin
						out_valid_q <= 1'b1;
						out_char_q  <= itd_pkg::CHAR_ERR;
						out_last_q  <= 1'b1;
						out_bad_q   <= 1'b1;
						state_q     <= B_IDLE;
					end
				end
				B_EMIT: begin
					data_ok_q <= 1'b1;
					if (put_sign) begin
						out_valid_q <= 1'b1;
						out_char_q  <= itd_pkg::CHAR_MINUS;
						out_last_q  <= 1'b0;
						out_bad_q   <= 1'b0;
						sign_pend_q <= 1'b0;
					end
					if (put_digit) begin
						out_valid_q <= 1'b1;
						out_char_q  <= itd_pkg::glyph(ram_rdata);
						out_last_q  <= (ptr_q == '0);
						out_bad_q   <= 1'b0;
						if (ptr_q == '0)
							state_q <= B_IDLE;
						else
							ptr_q <= ptr_q - 1'b1;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_char_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_bad_q;

endmodule

`default_nettype wire

/* src/integer_to_radix_digits.sv */
// Signed integer to ASCII digits in base 2..16, most significant digit first,
// '-' ahead of negative values; an out-of-range radix gives one error transfer
// (character 0, tuser high, tlast high). Inputs go through a two-entry queue,
// so up to two transfers are taken while a conversion runs. The shared long-division
// unit retires 8 magnitude bits a cycle, passing over every byte of the magnitude
// for each digit; characters then leave one per cycle from the digit RAM while
// m_tready is high.
// Depends on itd_pkg, itd_front, itd_fifo, itd_back and the defines header.
`default_nettype none
`include "integer_to_radix_digits_defines.svh"

module integer_to_radix_digits #(
	parameter int unsigned VALUE_BITS = 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [itd_pkg::IN_W-1:0]  s_tdata,  // number[31:0], radix[36:32], zero pad
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	output logic      [itd_pkg::OUT_W-1:0] m_tdata,  // ascii_char[6:0], zero pad
	output logic                           m_tlast,  // last_char
	output logic                           m_tuser   // bad_radix
);

	localparam int unsigned CMD_W = $bits(itd_pkg::cmd_t);
	localparam int unsigned ENT_W = CMD_W + VALUE_BITS;

	logic                       f_push;
	logic                       f_full;
	itd_pkg::cmd_t              f_cmd;
	logic [VALUE_BITS-1:0]      f_mag;
	logic                       b_valid;
	logic                       b_pop;
	logic [ENT_W-1:0]           b_entry;
	itd_pkg::cmd_t              b_cmd;
	logic [VALUE_BITS-1:0]      b_mag;
	logic [itd_pkg::CHAR_W-1:0] m_char;

	itd_front #(
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.number   (s_tdata[itd_pkg::NUM_W-1:0]),
		.radix    (s_tdata[itd_pkg::NUM_W +: itd_pkg::RADIX_W]),
		.q_full   (f_full),
		.q_push   (f_push),
		.q_cmd    (f_cmd),
		.q_mag    (f_mag)
	);

	itd_fifo #(
		.WIDTH (ENT_W),
		.DEPTH (2)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.din    ({f_cmd, f_mag}),
		.full   (f_full),
		.pop    (b_pop),
		.valid  (b_valid),
		.dout   (b_entry)
	);

	assign b_cmd = itd_pkg::cmd_t'(b_entry[ENT_W-1:VALUE_BITS]);
	assign b_mag = b_entry[VALUE_BITS-1:0];

	itd_back #(
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (b_valid),
		.q_cmd    (b_cmd),
		.q_mag    (b_mag),
		.q_pop    (b_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	assign m_char = m_tdata[itd_pkg::CHAR_W-1:0];

	`ITD_ASSERT_NOW(a_err_single, m_tvalid && m_tuser, m_tlast && m_char == '0, "bad error transfer")
	`ITD_ASSERT_NOW(a_minus_mid, m_tvalid && m_char == itd_pkg::CHAR_MINUS, !m_tlast, "bad minus")
	`ITD_ASSERT_NOW(a_char_nonzero, m_tvalid && !m_tuser, m_char != itd_pkg::CHAR_ERR, "null char")
	`ITD_ASSERT_NEXT(a_push_pop_queue, f_full && !b_pop, f_full, "queue drained without a pop")

endmodule

`default_nettype wire
